[hw/rtl/sem_pkg.sv]
package sem_pkg;

	// line store depth, default for the top level parameter
	localparam int SEM_MAX_LINE = 2048;
	// row limit is fixed by the 11-bit coordinate fields
	localparam int SEM_MAX_ROWS = 2048;

	localparam int SEM_CFG_W  = 12;
	localparam int SEM_PIX_W  = 8;
	localparam int SEM_XY_W   = 11;
	localparam int SEM_GRAD_W = 11;

	localparam int SEM_RST_WIDTH  = 1200;
	localparam int SEM_RST_HEIGHT = 800;

	localparam int SEM_IDX_W = 2;
	typedef enum logic [SEM_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1
	} sem_reg_t;

	// window centre position that travels with each result
	typedef struct packed {
		logic                valid;
		logic [SEM_XY_W-1:0] x;
		logic [SEM_XY_W-1:0] y;
	} sem_tag_t;

	// partial state of the digit-by-digit square root
	typedef struct packed {
		logic [8:0] rem;
		logic [7:0] root;
	} sem_sqrt_t;

	// four restoring square root steps: one result bit per pair of input bits
	function automatic sem_sqrt_t sem_sqrt_step4(input sem_sqrt_t st, input logic [7:0] bits);
		sem_sqrt_t   r;
		logic [10:0] acc;
		logic [10:0] trial;
		r = st;
		for (int i = 3; i >= 0; i--) begin
			acc   = {r.rem, bits[2*i+1 -: 2]};
			trial = {1'b0, r.root, 2'b01};
			if (acc >= trial) begin
				r.rem  = 9'(acc - trial);
				r.root = {r.root[6:0], 1'b1};
			end else begin
				r.rem  = 9'(acc);
				r.root = {r.root[6:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

[hw/rtl/sem_magnitude.sv]
module sem_magnitude (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  adv,
	input  sem_pkg::sem_tag_t                     tag_in,
	input  logic signed [sem_pkg::SEM_GRAD_W-1:0] gx,
	input  logic signed [sem_pkg::SEM_GRAD_W-1:0] gy,
	output sem_pkg::sem_tag_t                     tag_out,
	output logic [sem_pkg::SEM_PIX_W-1:0]         magnitude
);
	import sem_pkg::*;

	logic signed [2*SEM_GRAD_W-1:0] sqx, sqy;
	logic [2*SEM_GRAD_W-1:0]        sq_sum;

	logic        v_s3, v_s4, v_s5;
	logic [SEM_XY_W-1:0] x_s3, y_s3, x_s4, y_s4, x_s5, y_s5;
	logic [19:0] half_s3;
	logic        sat_s4;
	sem_sqrt_t   st_s4;
	logic [7:0]  lo_s4;
	sem_sqrt_t   st_fin;
	logic [7:0]  mag_s5;

	// |g| <= 1020, so the sum of squares stays below 2^21
	assign sqx    = gx * gx;
	assign sqy    = gy * gy;
	assign sq_sum = {1'b0, sqx[2*SEM_GRAD_W-2:0]} + {1'b0, sqy[2*SEM_GRAD_W-2:0]};
	assign st_fin = sem_sqrt_step4(st_s4, lo_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s3 <= tag_in.valid;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s3    <= tag_in.x;
			y_s3    <= tag_in.y;
			half_s3 <= sq_sum[20:1];
			x_s4    <= x_s3;
			y_s4    <= y_s3;
			sat_s4  <= |half_s3[19:16];
			st_s4   <= sem_sqrt_step4('0, half_s3[15:8]);
			lo_s4   <= half_s3[7:0];
			x_s5    <= x_s4;
			y_s5    <= y_s4;
			mag_s5  <= sat_s4 ? 8'hFF : st_fin.root;
		end
	end

	assign tag_out   = '{valid: v_s5, x: x_s5, y: y_s5};
	assign magnitude = mag_s5;

endmodule

[hw/rtl/sobel_edge_magnitude.sv]
// Each accepted pixel moves through s1, s2, s3 and s4 into the output register s5.
// Throughput: one pixel per cycle; the whole pipeline stalls while the output is held.
// Pixels on the frame border pass through without a result.
// Reset (arst_n low): counters and window clear, width 1200 and height 800 take effect.
// Line stores are not cleared; every entry up to the frame width is written during the first line of a frame.
module sobel_edge_magnitude #(
	parameter int MAX_LINE = sem_pkg::SEM_MAX_LINE
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// pixel input
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata,  // [7:0] gray
	// result output
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [31:0]                       m_axis_tdata,  // [7:0] magnitude,
	                                                         // [18:8] out_x, [29:19] out_y
	// register writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sem_pkg::SEM_IDX_W-1:0]     cfg_index,
	input  logic [sem_pkg::SEM_CFG_W-1:0]     cfg_data
);
	import sem_pkg::*;

	localparam int AW     = $clog2(MAX_LINE);
	localparam int EW     = (AW >= SEM_CFG_W) ? AW + 1 : SEM_CFG_W + 1;
	localparam int XW     = (AW > SEM_XY_W) ? AW : SEM_XY_W;
	localparam int RST_W  = (SEM_RST_WIDTH > MAX_LINE) ? MAX_LINE : SEM_RST_WIDTH;

	// ---------------------------------------------------------------
	// Global flow control: every stage moves when the output can move.
	// ---------------------------------------------------------------
	logic adv, acc;
	sem_tag_t tag_out;

	assign adv           = !tag_out.valid || m_axis_tready;
	assign s_axis_tready = adv;
	assign acc           = s_axis_tvalid && adv;
	assign cfg_ready     = 1'b1;

	// ---------------------------------------------------------------
	// Frame size registers, held as clamped last index of line/frame.
	// ---------------------------------------------------------------
	logic [AW-1:0]       wlast_q;
	logic [SEM_XY_W-1:0] hlast_q;
	logic [EW-1:0]        w_ext, w_clamp;
	logic [SEM_CFG_W-1:0] h_clamp;

	always_comb begin
		w_ext = EW'(cfg_data);
		if (w_ext < EW'(3))
			w_clamp = EW'(3);
		else if (w_ext > EW'(MAX_LINE))
			w_clamp = EW'(MAX_LINE);
		else
			w_clamp = w_ext;
		if (cfg_data < SEM_CFG_W'(3))
			h_clamp = SEM_CFG_W'(3);
		else if (cfg_data > SEM_CFG_W'(SEM_MAX_ROWS))
			h_clamp = SEM_CFG_W'(SEM_MAX_ROWS);
		else
			h_clamp = cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q <= AW'(RST_W - 1);
			hlast_q <= SEM_XY_W'(SEM_RST_HEIGHT - 1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  wlast_q <= AW'(w_clamp - EW'(1));
				REG_FRAME_HEIGHT: hlast_q <= SEM_XY_W'(h_clamp - SEM_CFG_W'(1));
				default: ;  // writes beyond the register list are dropped
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Raster position of the next pixel.
	// ---------------------------------------------------------------
	logic [AW-1:0]       col_q;
	logic [SEM_XY_W-1:0] row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			// >= rather than == so a size lowered mid-frame still wraps
			if (col_q >= wlast_q) begin
				col_q <= '0;
				row_q <= (row_q >= hlast_q) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Line store memory: [15:8] two lines back, [7:0] previous line.
	// Read at accept, written back one stage later with the line pair
	// shifted down. Consecutive pixels never share a column, so the
	// write in s1 and the read of the next pixel never collide.
	// ---------------------------------------------------------------
	logic [15:0] line_mem [MAX_LINE];

	logic          v_s1;
	logic [7:0]    px_s1;
	logic [AW-1:0] col_s1;
	logic [SEM_XY_W-1:0] row_s1;
	logic [15:0]   rd_s1;
	logic          wr_s1;

	assign wr_s1 = v_s1 && adv;

	always_ff @(posedge clk) begin
		if (acc)
			rd_s1 <= line_mem[col_q];
		if (wr_s1)
			line_mem[col_s1] <= {rd_s1[7:0], px_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= acc;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			px_s1  <= s_axis_tdata[7:0];
			col_s1 <= col_q;
			row_s1 <= row_q;
		end
	end

	// ---------------------------------------------------------------
	// 3x3 window, row-major (0..2 top, 6..8 bottom), shifts left per pixel.
	// Gradients are formed on the shifted window and registered in s2.
	// ---------------------------------------------------------------
	logic [7:0] win_q [9];
	logic [7:0] win_n [9];
	logic [9:0] xl, xr, yt, yb;
	logic signed [SEM_GRAD_W-1:0] gx_n, gy_n;
	logic signed [SEM_GRAD_W-1:0] gx_s2, gy_s2;
	logic [XW-1:0] x_full;
	logic                vld_s2;
	logic [SEM_XY_W-1:0] x_s2, y_s2;
	sem_tag_t tag_s2;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_n[r*3+0] = win_q[r*3+1];
			win_n[r*3+1] = win_q[r*3+2];
		end
		win_n[2] = rd_s1[15:8];
		win_n[5] = rd_s1[7:0];
		win_n[8] = px_s1;
		xl = 10'(win_n[0]) + {1'b0, win_n[3], 1'b0} + 10'(win_n[6]);
		xr = 10'(win_n[2]) + {1'b0, win_n[5], 1'b0} + 10'(win_n[8]);
		yt = 10'(win_n[0]) + {1'b0, win_n[1], 1'b0} + 10'(win_n[2]);
		yb = 10'(win_n[6]) + {1'b0, win_n[7], 1'b0} + 10'(win_n[8]);
		gx_n = $signed({1'b0, xl}) - $signed({1'b0, xr});
		gy_n = $signed({1'b0, yt}) - $signed({1'b0, yb});
		x_full = XW'(col_s1) - XW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++)
				win_q[i] <= '0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			if (v_s1) begin
				for (int i = 0; i < 9; i++)
					win_q[i] <= win_n[i];
			end
			// interior pixels only: window complete from column 2, row 2 on
			vld_s2 <= v_s1 && (col_s1 >= AW'(2)) && (row_s1 >= SEM_XY_W'(2));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gx_s2 <= gx_n;
			gy_s2 <= gy_n;
			x_s2  <= x_full[SEM_XY_W-1:0];
			y_s2  <= row_s1 - 1'b1;
		end
	end

	assign tag_s2 = '{valid: vld_s2, x: x_s2, y: y_s2};

	// ---------------------------------------------------------------
	// Squares, halving, saturated square root, output register.
	// ---------------------------------------------------------------
	logic [7:0] magnitude;

	sem_magnitude u_mag (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.tag_in    (tag_s2),
		.gx        (gx_s2),
		.gy        (gy_s2),
		.tag_out   (tag_out),
		.magnitude (magnitude)
	);

	assign m_axis_tvalid = tag_out.valid;
	assign m_axis_tdata  = {2'b00, tag_out.y, tag_out.x, magnitude};

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && wr_s1) |-> (col_q != col_s1))
		else $error("line store read and write hit the same column");

	a_read_held: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> (v_s1 && $stable(rd_s1) && $stable(col_s1)))
		else $error("stalled s1 lost its line store data");

	a_interior_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (tag_out.x != '0 && tag_out.y != '0))
		else $error("result issued for a border pixel");

	a_col_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> (32'(col_q) < MAX_LINE))
		else $error("column outside line store");

endmodule
